// ----- hw/rtl/mngm_pkg.sv -----
`default_nettype none
package mngm_pkg;

  localparam int unsigned NUM_CELLS    = 18;
  localparam int unsigned NUM_CHANNELS = 16;
  localparam int unsigned COUNT_W      = 16;

  localparam int unsigned CELL_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int unsigned CHAN_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned DEPTH  = NUM_CELLS * NUM_CHANNELS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_W) - 33'd1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = {{(COUNT_W-1){1'b0}}, 1'b1};

  // midi status high nibble
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [7:0] STATUS_SYSTEM = 8'hF0;

  localparam logic [6:0] LEVEL_FULL = 7'd127;
  localparam logic [7:0] NOTE_NONE  = 8'hFF;
  localparam int unsigned NOTE_BASE = 36;

  // configuration register index
  localparam logic [1:0] REG_INPUT_CHANNEL = 2'd0;
  localparam logic [1:0] REG_MPE_MODE      = 2'd1;
  localparam logic [1:0] REG_VELOCITY_MODE = 2'd2;
  localparam logic [1:0] REG_MIN_PULSE     = 2'd3;

  typedef enum logic [2:0] {
    ACT_MIDI   = 3'd0,
    ACT_TICK   = 3'd1,
    ACT_READ   = 3'd2,
    ACT_ARM    = 3'd3,
    ACT_CANCEL = 3'd4,
    ACT_ASSIGN = 3'd5,
    ACT_PANIC  = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_NOTE,
    ST_TICK,
    ST_DRAIN,
    ST_READ
  } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/midi_note_to_gate_mapper.sv -----
// a read result is registered after the item is latched, read from memory in ST_EXEC and output in ST_READ
// one item at a time: a note sweeps every cell once, a tick sweeps every cell and its slots
//   (all channels in mpe mode, channel 0 otherwise) with one counter read-modify-write per cycle
// a read waits in ST_READ while the previous result is not taken; panic reruns the clearing pass
// reset: synchronous; afterwards a clearing pass walks every entry of the gate and
//   counter memories, s_tready low meanwhile; config writes are taken as ever
`default_nettype none
module midi_note_to_gate_mapper (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // status_byte[7:0], data_one[14:8], data_two[21:15], cell_index[26:22],
  // chan_index[30:27], assigned_note[38:31], zero fill
  input  wire logic [39:0] s_tdata,
  // action[2:0]
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // gate_on[0], level[7:1], learn_pending[8], zero fill
  output logic [15:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned NC  = mngm_pkg::NUM_CELLS;
  localparam int unsigned NCH = mngm_pkg::NUM_CHANNELS;
  localparam int unsigned CW  = mngm_pkg::COUNT_W;
  localparam int unsigned AW  = mngm_pkg::ADDR_W;
  localparam int unsigned CLW = mngm_pkg::CELL_W;
  localparam int unsigned CHW = mngm_pkg::CHAN_W;

  function automatic logic [AW-1:0] make_addr(input logic [CLW-1:0] cell_id,
                                              input logic [CHW-1:0] chan);
    int unsigned a;
    a = int'(cell_id) * NCH + int'(chan);
    return a[AW-1:0];
  endfunction

  mngm_pkg::state_t state, state_next;

  // configuration
  logic [4:0]    input_channel;
  logic          mpe_mode;
  logic          velocity_mode;
  logic [15:0]   min_pulse_ticks;

  // latched item
  mngm_pkg::action_t action;
  logic [7:0]    status_byte;
  logic [6:0]    data_one;
  logic [6:0]    data_two;
  logic [4:0]    cell_index;
  logic [3:0]    chan_index;
  logic [7:0]    assigned_note;

  logic [7:0]    cell_note [NC];
  logic          learn_armed;
  logic [CLW-1:0] learn_cell;

  logic [CLW-1:0] sweep_cell;
  logic [CHW-1:0] sweep_chan;
  logic [AW-1:0]  sweep_addr;
  logic [CHW-1:0] chan_last;
  logic           sweep_last;

  // gate, counter and velocity memories
  logic          hold_mem [mngm_pkg::DEPTH];
  logic [CW-1:0] cnt_mem  [mngm_pkg::DEPTH];
  logic [6:0]    vel_mem  [mngm_pkg::DEPTH];
  logic          hold_rd;
  logic [CW-1:0] cnt_rd;
  logic [6:0]    vel_rd;

  logic          hold_we, cnt_we, vel_we, rd_en;
  logic [AW-1:0] waddr, rd_addr;
  logic          hold_wdata;
  logic [CW-1:0] cnt_wdata;

  logic          wb_valid;
  logic [AW-1:0] wb_addr;

  // decode of the latched item
  logic          chan_ok, is_note, note_on, slot_ok, note_go;
  logic [3:0]    nib;
  logic [CHW-1:0] slot;
  logic          cell_ok;
  logic          read_ok;
  logic          note_match;
  logic [32:0]   min_ext;
  logic [CW-1:0] load_value;
  logic          out_free;
  logic          gate_res;
  logic [6:0]    level_res;

  assign nib     = status_byte[3:0];
  assign chan_ok = (input_channel == 5'd0) || (status_byte >= mngm_pkg::STATUS_SYSTEM)
                   || ({1'b0, nib} == (input_channel - 5'd1));
  assign is_note = status_byte[7:4] inside {mngm_pkg::KIND_NOTE_ON, mngm_pkg::KIND_NOTE_OFF};
  assign slot_ok = !mpe_mode || ({28'd0, nib} < NCH);
  assign slot    = mpe_mode ? nib[CHW-1:0] : '0;
  assign note_on = (status_byte[7:4] == mngm_pkg::KIND_NOTE_ON) && (data_two != 7'd0);
  assign note_go = chan_ok && is_note && slot_ok;

  assign cell_ok = {27'd0, cell_index} < NC;
  assign read_ok = cell_ok && ({28'd0, chan_index} < NCH)
                   && (mpe_mode || chan_index == 4'd0);

  assign note_match = cell_note[sweep_cell] == {1'b0, data_one};

  assign min_ext    = {17'd0, min_pulse_ticks};
  assign load_value = (min_ext > mngm_pkg::COUNT_MAX) ? mngm_pkg::COUNT_MAX[CW-1:0]
                                                      : min_ext[CW-1:0];

  assign sweep_addr = make_addr(sweep_cell, sweep_chan);
  assign chan_last  = (state == mngm_pkg::ST_TICK && !mpe_mode) ? '0 : CHW'(NCH - 1);
  assign sweep_last = (sweep_cell == CLW'(NC - 1)) && (sweep_chan == chan_last);

  assign out_free  = !m_tvalid || m_tready;
  assign gate_res  = read_ok && (hold_rd || cnt_rd != '0);
  assign level_res = gate_res ? (velocity_mode ? vel_rd : mngm_pkg::LEVEL_FULL) : 7'd0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mngm_pkg::ST_CLEAR: if (sweep_last) state_next = mngm_pkg::ST_IDLE;
      mngm_pkg::ST_IDLE:  if (s_tvalid) state_next = mngm_pkg::ST_EXEC;
      mngm_pkg::ST_EXEC: begin
        case (action)
          mngm_pkg::ACT_MIDI:  state_next = note_go ? mngm_pkg::ST_NOTE : mngm_pkg::ST_IDLE;
          mngm_pkg::ACT_TICK:  state_next = mngm_pkg::ST_TICK;
          mngm_pkg::ACT_READ:  state_next = mngm_pkg::ST_READ;
          mngm_pkg::ACT_PANIC: state_next = mngm_pkg::ST_CLEAR;
          default:             state_next = mngm_pkg::ST_IDLE;
        endcase
      end
      mngm_pkg::ST_NOTE:  if (sweep_cell == CLW'(NC - 1)) state_next = mngm_pkg::ST_IDLE;
      mngm_pkg::ST_TICK:  if (sweep_last) state_next = mngm_pkg::ST_DRAIN;
      mngm_pkg::ST_DRAIN: state_next = mngm_pkg::ST_IDLE;
      mngm_pkg::ST_READ:  if (out_free) state_next = mngm_pkg::ST_IDLE;
      default:            state_next = mngm_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    s_tready   = 1'b0;
    hold_we    = 1'b0;
    cnt_we     = 1'b0;
    vel_we     = 1'b0;
    rd_en      = 1'b0;
    waddr      = sweep_addr;
    rd_addr    = sweep_addr;
    hold_wdata = 1'b0;
    cnt_wdata  = '0;
    // decrement write-back in the cycle after the tick read
    if (wb_valid) begin
      cnt_we    = 1'b1;
      waddr     = wb_addr;
      cnt_wdata = (cnt_rd != '0) ? (cnt_rd - mngm_pkg::COUNT_ONE) : cnt_rd;
    end
    case (state)
      mngm_pkg::ST_CLEAR: begin
        hold_we = 1'b1;
        cnt_we  = 1'b1;
      end
      mngm_pkg::ST_IDLE: s_tready = 1'b1;
      mngm_pkg::ST_EXEC: begin
        rd_en   = (action == mngm_pkg::ACT_READ) && read_ok;
        rd_addr = make_addr(cell_index[CLW-1:0], chan_index[CHW-1:0]);
      end
      mngm_pkg::ST_NOTE: begin
        waddr      = make_addr(sweep_cell, slot);
        hold_we    = note_match;
        hold_wdata = note_on;
        cnt_we     = note_match && note_on;
        vel_we     = note_match && note_on;
        cnt_wdata  = load_value;
      end
      mngm_pkg::ST_TICK: rd_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hold_we) hold_mem[waddr] <= hold_wdata;
    if (cnt_we)  cnt_mem[waddr]  <= cnt_wdata;
    if (vel_we)  vel_mem[waddr]  <= data_two;
    if (rd_en) begin
      hold_rd <= hold_mem[rd_addr];
      cnt_rd  <= cnt_mem[rd_addr];
      vel_rd  <= vel_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      action        <= mngm_pkg::action_t'(s_tuser);
      status_byte   <= s_tdata[7:0];
      data_one      <= s_tdata[14:8];
      data_two      <= s_tdata[21:15];
      cell_index    <= s_tdata[26:22];
      chan_index    <= s_tdata[30:27];
      assigned_note <= s_tdata[38:31];
    end
    wb_addr <= sweep_addr;
    if (state == mngm_pkg::ST_READ && out_free) begin
      m_tdata <= {7'd0, learn_armed, level_res, gate_res};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= mngm_pkg::ST_CLEAR;
      input_channel   <= 5'd0;
      mpe_mode        <= 1'b0;
      velocity_mode   <= 1'b0;
      min_pulse_ticks <= 16'd48;
      learn_armed     <= 1'b0;
      learn_cell      <= '0;
      sweep_cell      <= '0;
      sweep_chan      <= '0;
      wb_valid        <= 1'b0;
      m_tvalid        <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        cell_note[i] <= 8'(mngm_pkg::NOTE_BASE + i);
      end
    end else begin
      state    <= state_next;
      wb_valid <= (state == mngm_pkg::ST_TICK);

      if (cfg_we) begin
        case (cfg_addr)
          mngm_pkg::REG_INPUT_CHANNEL: input_channel   <= cfg_data[4:0];
          mngm_pkg::REG_MPE_MODE:      mpe_mode        <= cfg_data[0];
          mngm_pkg::REG_VELOCITY_MODE: velocity_mode   <= cfg_data[0];
          mngm_pkg::REG_MIN_PULSE:     min_pulse_ticks <= cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == mngm_pkg::ST_READ && out_free) m_tvalid <= 1'b1;

      case (state)
        mngm_pkg::ST_CLEAR, mngm_pkg::ST_TICK: begin
          if (sweep_chan == chan_last) begin
            sweep_chan <= '0;
            sweep_cell <= sweep_cell + CLW'(1);
          end else begin
            sweep_chan <= sweep_chan + CHW'(1);
          end
        end
        mngm_pkg::ST_NOTE: sweep_cell <= sweep_cell + CLW'(1);
        mngm_pkg::ST_EXEC: begin
          sweep_cell <= '0;
          sweep_chan <= '0;
          case (action)
            mngm_pkg::ACT_MIDI: begin
              // learn takes the note and drops it from every other cell
              if (note_go && note_on && learn_armed) begin
                for (int i = 0; i < NC; i++) begin
                  if (CLW'(i) == learn_cell) begin
                    cell_note[i] <= {1'b0, data_one};
                  end else if (cell_note[i] == {1'b0, data_one}) begin
                    cell_note[i] <= mngm_pkg::NOTE_NONE;
                  end
                end
                learn_armed <= 1'b0;
              end
            end
            mngm_pkg::ACT_ARM: begin
              if (cell_ok) begin
                learn_armed <= 1'b1;
                learn_cell  <= cell_index[CLW-1:0];
              end
            end
            mngm_pkg::ACT_CANCEL: learn_armed <= 1'b0;
            mngm_pkg::ACT_ASSIGN: begin
              if (cell_ok) begin
                for (int i = 0; i < NC; i++) begin
                  if (CLW'(i) == cell_index[CLW-1:0]) begin
                    cell_note[i] <= assigned_note[7] ? mngm_pkg::NOTE_NONE : assigned_note;
                  end else if (!assigned_note[7] && cell_note[i] == assigned_note) begin
                    cell_note[i] <= mngm_pkg::NOTE_NONE;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
